// ===== rtl/rsst_pkg.sv =====
// Shared widths, types, codes and the microcode program of the random sampling set table.
// Used by the channel interfaces, the table unit and the testbench; depends on nothing.
package rsst_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int DRAW_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int BIT_W    = $clog2(DRAW_W);

    typedef logic [FUNC_W-1:0]          func_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [DRAW_W-1:0]          draw_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [BIT_W-1:0]           bit_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_REMOVE = 2'd1;
    localparam func_t FUNC_SAMPLE = 2'd2;
    localparam func_t FUNC_NOP    = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_MISS  = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE     = 5'd0;
    localparam pc_t STEP_DISPATCH = 5'd1;
    localparam pc_t STEP_CHK_NOP  = 5'd2;
    localparam pc_t STEP_SCAN_A   = 5'd3;
    localparam pc_t STEP_SCAN_B   = 5'd4;
    localparam pc_t STEP_HIT      = 5'd5;
    localparam pc_t STEP_MOVE     = 5'd6;
    localparam pc_t STEP_ABSENT   = 5'd7;
    localparam pc_t STEP_CHK_FULL = 5'd8;
    localparam pc_t STEP_APPEND   = 5'd9;
    localparam pc_t STEP_SAMPLE   = 5'd10;
    localparam pc_t STEP_DIV      = 5'd11;
    localparam pc_t STEP_RD_REM   = 5'd12;
    localparam pc_t STEP_TAKE     = 5'd13;
    localparam pc_t STEP_EMPTY    = 5'd14;
    localparam pc_t STEP_MISS     = 5'd15;
    localparam pc_t STEP_FULL     = 5'd16;
    localparam pc_t STEP_FIN      = 5'd17;
    localparam pc_t STEP_RET      = 5'd18;

    localparam int ACT_W = 4;
    typedef logic [ACT_W-1:0] act_t;

    localparam act_t ACT_NONE      = 4'd0;
    localparam act_t ACT_LOAD      = 4'd1;
    localparam act_t ACT_SCAN_NEXT = 4'd2;
    localparam act_t ACT_RD_LAST   = 4'd3;
    localparam act_t ACT_MOVE_LAST = 4'd4;
    localparam act_t ACT_APPEND    = 4'd5;
    localparam act_t ACT_DIV_STEP  = 4'd6;
    localparam act_t ACT_RD_REM    = 4'd7;
    localparam act_t ACT_TAKE      = 4'd8;
    localparam act_t ACT_EMIT      = 4'd9;

    localparam int COND_W = 4;
    typedef logic [COND_W-1:0] cond_t;

    localparam cond_t COND_NEVER      = 4'd0;
    localparam cond_t COND_ALWAYS     = 4'd1;
    localparam cond_t COND_NOT_ACCEPT = 4'd2;
    localparam cond_t COND_IS_SAMPLE  = 4'd3;
    localparam cond_t COND_IS_NOP     = 4'd4;
    localparam cond_t COND_SCAN_END   = 4'd5;
    localparam cond_t COND_NOT_HIT    = 4'd6;
    localparam cond_t COND_IS_INSERT  = 4'd7;
    localparam cond_t COND_IS_REMOVE  = 4'd8;
    localparam cond_t COND_IS_FULL    = 4'd9;
    localparam cond_t COND_CNT_ZERO   = 4'd10;
    localparam cond_t COND_DIV_MORE   = 4'd11;
    localparam cond_t COND_OUT_BUSY   = 4'd12;

    typedef struct packed {
        act_t    act;
        logic    set_st;
        status_t st;
        cond_t   cond;
        pc_t     target;
    } uword_t;

    function automatic uword_t mk_uword(input act_t act, input logic set_st, input status_t st,
                                        input cond_t cond, input pc_t target);
        uword_t w;
        w.act    = act;
        w.set_st = set_st;
        w.st     = st;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control store: one word per step, jump to target when the condition holds.
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:     w = mk_uword(ACT_LOAD, 1'b0, ST_DONE, COND_NOT_ACCEPT, STEP_IDLE);
            STEP_DISPATCH: w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_IS_SAMPLE, STEP_SAMPLE);
            STEP_CHK_NOP:  w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_IS_NOP, STEP_FIN);
            STEP_SCAN_A:   w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_SCAN_END, STEP_ABSENT);
            STEP_SCAN_B:   w = mk_uword(ACT_SCAN_NEXT, 1'b0, ST_DONE, COND_NOT_HIT, STEP_SCAN_A);
            STEP_HIT:      w = mk_uword(ACT_RD_LAST, 1'b0, ST_DONE, COND_IS_INSERT, STEP_MISS);
            STEP_MOVE:     w = mk_uword(ACT_MOVE_LAST, 1'b0, ST_DONE, COND_ALWAYS, STEP_FIN);
            STEP_ABSENT:   w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_IS_REMOVE, STEP_MISS);
            STEP_CHK_FULL: w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_IS_FULL, STEP_FULL);
            STEP_APPEND:   w = mk_uword(ACT_APPEND, 1'b0, ST_DONE, COND_ALWAYS, STEP_FIN);
            STEP_SAMPLE:   w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_CNT_ZERO, STEP_EMPTY);
            STEP_DIV:      w = mk_uword(ACT_DIV_STEP, 1'b0, ST_DONE, COND_DIV_MORE, STEP_DIV);
            STEP_RD_REM:   w = mk_uword(ACT_RD_REM, 1'b0, ST_DONE, COND_NEVER, STEP_IDLE);
            STEP_TAKE:     w = mk_uword(ACT_TAKE, 1'b0, ST_DONE, COND_ALWAYS, STEP_FIN);
            STEP_EMPTY:    w = mk_uword(ACT_NONE, 1'b1, ST_EMPTY, COND_ALWAYS, STEP_FIN);
            STEP_MISS:     w = mk_uword(ACT_NONE, 1'b1, ST_MISS, COND_ALWAYS, STEP_FIN);
            STEP_FULL:     w = mk_uword(ACT_NONE, 1'b1, ST_FULL, COND_ALWAYS, STEP_FIN);
            STEP_FIN:      w = mk_uword(ACT_EMIT, 1'b0, ST_DONE, COND_OUT_BUSY, STEP_FIN);
            STEP_RET:      w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_ALWAYS, STEP_IDLE);
            default:       w = mk_uword(ACT_NONE, 1'b0, ST_DONE, COND_ALWAYS, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rsst_if.sv =====
// Request and response channel interfaces of the random sampling set table.
// Each carries valid, ready and one word of payload; depends on rsst_pkg.
interface rsst_req_if;
    logic                valid;
    logic                ready;
    rsst_pkg::func_t     func;
    rsst_pkg::value_t    value;
    rsst_pkg::draw_t     random_draw;

    modport source (output valid, output func, output value, output random_draw, input ready);
    modport sink   (input valid, input func, input value, input random_draw, output ready);
endinterface

interface rsst_rsp_if;
    logic                valid;
    logic                ready;
    rsst_pkg::status_t   status;
    rsst_pkg::value_t    sampled_value;
    rsst_pkg::count_t    element_count;

    modport source (output valid, output status, output sampled_value, output element_count,
                    input ready);
    modport sink   (input valid, input status, input sampled_value, input element_count,
                    output ready);
endinterface

// ===== rtl/random_sampling_set_table_unit.sv =====
// Random sampling set table: a microcoded sequencer over one element store RAM.
// Depends on rsst_pkg, rsst_if (request and response channels) and rsst_ram.
//
// Use: the req channel takes one word per operation (func, value, random_draw):
// insert, remove or sample. The rsp channel returns exactly one word per request
// (status, sampled_value, element_count). A word moves when valid and ready are
// both high at a rising edge of clk.
// One request is worked on at a time. Insert and remove scan the live entries
// through the single RAM read port. Sample reduces random_draw modulo the count
// one bit per cycle. A duplicate, absent or no-op request ends after its scan or
// dispatch.
// The response sits in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and only its final step waits for the
// output register to drain.
// Reset (rst_n low, asynchronous) empties the set and drops any pending response.
// The store needs no clearing pass: only live entries are ever read.
module random_sampling_set_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    rsst_req_if.sink    req,
    rsst_rsp_if.source  rsp
);

    rsst_pkg::pc_t      pc_reg, pc_next;
    rsst_pkg::uword_t   uw;
    logic               accept;
    logic               hit;
    logic               out_busy;
    logic               taken;
    logic               emit;

    rsst_pkg::func_t    func_reg;
    rsst_pkg::value_t   key_reg;
    rsst_pkg::draw_t    draw_reg;
    rsst_pkg::cnt_t     idx_reg;
    rsst_pkg::cnt_t     cnt_reg, cnt_next;
    rsst_pkg::cnt_t     rem_reg;
    rsst_pkg::bit_t     bit_reg;
    rsst_pkg::status_t  st_reg;
    rsst_pkg::value_t   samp_reg;

    logic                          out_valid_reg, out_valid_next;
    rsst_pkg::status_t             out_status_reg;
    rsst_pkg::value_t              out_samp_reg;
    rsst_pkg::count_t              out_count_reg;

    logic [rsst_pkg::CNT_W:0]      rem_shift;
    logic [rsst_pkg::CNT_W:0]      rem_sub;
    logic                          ram_we;
    rsst_pkg::addr_t               ram_addr;
    logic [rsst_pkg::VALUE_W-1:0]  ram_wdata;
    logic [rsst_pkg::VALUE_W-1:0]  ram_rdata;

    rsst_ram #(
        .WIDTH (rsst_pkg::VALUE_W),
        .DEPTH (rsst_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign uw       = rsst_pkg::ucode(pc_reg);
    assign req.ready = (pc_reg == rsst_pkg::STEP_IDLE);
    assign accept   = req.valid && req.ready;
    assign hit      = (ram_rdata == key_reg);
    assign out_busy = out_valid_reg && !rsp.ready;
    assign emit     = (uw.act == rsst_pkg::ACT_EMIT) && !out_busy;

    assign rem_shift = {rem_reg, draw_reg[rsst_pkg::DRAW_W-1]};
    assign rem_sub   = rem_shift - {1'b0, cnt_reg};

    always_comb
    begin
        unique case (uw.cond)
            rsst_pkg::COND_NEVER:      taken = 1'b0;
            rsst_pkg::COND_ALWAYS:     taken = 1'b1;
            rsst_pkg::COND_NOT_ACCEPT: taken = !accept;
            rsst_pkg::COND_IS_SAMPLE:  taken = (func_reg == rsst_pkg::FUNC_SAMPLE);
            rsst_pkg::COND_IS_NOP:     taken = (func_reg == rsst_pkg::FUNC_NOP);
            rsst_pkg::COND_SCAN_END:   taken = (idx_reg == cnt_reg);
            rsst_pkg::COND_NOT_HIT:    taken = !hit;
            rsst_pkg::COND_IS_INSERT:  taken = (func_reg == rsst_pkg::FUNC_INSERT);
            rsst_pkg::COND_IS_REMOVE:  taken = (func_reg == rsst_pkg::FUNC_REMOVE);
            rsst_pkg::COND_IS_FULL:    taken = (cnt_reg >= rsst_pkg::CNT_W'(rsst_pkg::CAPACITY));
            rsst_pkg::COND_CNT_ZERO:   taken = (cnt_reg == '0);
            rsst_pkg::COND_DIV_MORE:   taken = (bit_reg != rsst_pkg::BIT_W'(rsst_pkg::DRAW_W - 1));
            rsst_pkg::COND_OUT_BUSY:   taken = out_busy;
            default:                   taken = 1'b0;
        endcase
        pc_next = taken ? uw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        ram_we    = (uw.act == rsst_pkg::ACT_MOVE_LAST) || (uw.act == rsst_pkg::ACT_APPEND);
        ram_wdata = (uw.act == rsst_pkg::ACT_APPEND) ? key_reg : ram_rdata;
        unique case (uw.act)
            rsst_pkg::ACT_RD_LAST: ram_addr = rsst_pkg::ADDR_W'(cnt_reg - 1'b1);
            rsst_pkg::ACT_APPEND:  ram_addr = rsst_pkg::ADDR_W'(cnt_reg);
            rsst_pkg::ACT_RD_REM:  ram_addr = rsst_pkg::ADDR_W'(rem_reg);
            default:               ram_addr = rsst_pkg::ADDR_W'(idx_reg);
        endcase
    end

    always_comb
    begin
        unique case (uw.act)
            rsst_pkg::ACT_MOVE_LAST: cnt_next = cnt_reg - 1'b1;
            rsst_pkg::ACT_APPEND:    cnt_next = cnt_reg + 1'b1;
            default:                 cnt_next = cnt_reg;
        endcase
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= rsst_pkg::STEP_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((uw.act == rsst_pkg::ACT_LOAD) && accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.value;
            draw_reg <= req.random_draw;
            idx_reg  <= '0;
            rem_reg  <= '0;
            bit_reg  <= '0;
            st_reg   <= rsst_pkg::ST_DONE;
            samp_reg <= '0;
        end
        if ((uw.act == rsst_pkg::ACT_SCAN_NEXT) && !hit)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (uw.act == rsst_pkg::ACT_DIV_STEP)
        begin
            rem_reg  <= (rem_shift >= {1'b0, cnt_reg}) ? rsst_pkg::CNT_W'(rem_sub)
                                                       : rsst_pkg::CNT_W'(rem_shift);
            draw_reg <= {draw_reg[rsst_pkg::DRAW_W-2:0], 1'b0};
            bit_reg  <= bit_reg + 1'b1;
        end
        if (uw.act == rsst_pkg::ACT_TAKE)
        begin
            samp_reg <= ram_rdata;
        end
        if (uw.set_st)
        begin
            st_reg <= uw.st;
        end
        if (emit)
        begin
            out_status_reg <= st_reg;
            out_samp_reg   <= samp_reg;
            out_count_reg  <= rsst_pkg::COUNT_W'(cnt_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.sampled_value = out_samp_reg;
    assign rsp.element_count = out_count_reg;

    // The count never exceeds the store size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rsst_pkg::CNT_W'(rsst_pkg::CAPACITY))
        else $error("element count above capacity");

    // The count moves only through an append or a move of the last entry.
    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
        ($past(uw.act) == rsst_pkg::ACT_APPEND || $past(uw.act) == rsst_pkg::ACT_MOVE_LAST))
        else $error("element count changed outside an append or removal");

    // An append never writes when the store is full.
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.act == rsst_pkg::ACT_APPEND) |-> (cnt_reg < rsst_pkg::CNT_W'(rsst_pkg::CAPACITY)))
        else $error("append into a full store");

    // A response word appears only out of the final step of the program.
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == rsst_pkg::STEP_FIN))
        else $error("response raised outside the final step");

endmodule

// ===== rtl/rsst_ram.sv =====
// Generic single-port RAM with a registered read, used for the element store.
// Stand-alone; no package dependency.
module rsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of random_sampling_set_table_unit: a directed script, then random
// insert, remove, sample and no-op words, each response checked against a script or mirror.
// Depends on rsst_pkg, rsst_if and the block itself.
module tb_top;

    localparam int RANDOM_WORDS = 1500;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int SCRIPT_LEN   = 25;

    typedef struct packed {
        rsst_pkg::status_t status;
        rsst_pkg::value_t  sampled;
        rsst_pkg::count_t  count;
    } rsp_word_t;

    typedef struct packed {
        rsst_pkg::func_t  func;
        rsst_pkg::value_t value;
        rsst_pkg::draw_t  draw;
        logic             literal;
        rsp_word_t        rsp;
    } script_row_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MASK} ready_mode_t;

    logic clk;
    logic rst_n;

    rsst_req_if req_ch ();
    rsst_rsp_if rsp_ch ();

    random_sampling_set_table_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rsst_pkg::value_t set_mirror [rsst_pkg::CAPACITY];
    int               live_cnt;
    rsp_word_t        pending_rsp [$];
    int               mismatches;
    int               idle_cycles;
    int               burst_left;
    ready_mode_t      ready_mode;
    int               ready_left;
    logic [15:0]      ready_mask;

    script_row_t script [SCRIPT_LEN] = '{
        '{rsst_pkg::FUNC_SAMPLE, 32'h0000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_EMPTY, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'h0000_0005, 16'h0000, 1'b1,
          '{rsst_pkg::ST_MISS, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_NOP, 32'h7fff_ffff, 16'hffff, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_INSERT, 32'h8000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd1}},
        '{rsst_pkg::FUNC_INSERT, 32'h7fff_ffff, 16'hffff, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd2}},
        '{rsst_pkg::FUNC_INSERT, 32'h8000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_MISS, 32'h0, 7'd2}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h0000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h8000_0000, 7'd2}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h1234_5678, 16'hffff, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h7fff_ffff, 7'd2}},
        '{rsst_pkg::FUNC_INSERT, 32'h0000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd3}},
        '{rsst_pkg::FUNC_INSERT, 32'hffff_ffff, 16'h0000, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd4}},
        '{rsst_pkg::FUNC_REMOVE, 32'h8000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd3}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h0000_0000, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h0000_0000, 16'h0002, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'h8000_0000, 16'h0000, 1'b1,
          '{rsst_pkg::ST_MISS, 32'h0, 7'd3}},
        '{rsst_pkg::FUNC_REMOVE, 32'h0000_0000, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_NOP, 32'h0000_0000, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_INSERT, 32'h5555_5555, 16'h5555, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_INSERT, 32'haaaa_aaaa, 16'haaaa, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_SAMPLE, 32'haaaa_aaaa, 16'h5555, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h5555_5555, 16'haaaa, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'hffff_ffff, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'h7fff_ffff, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'h5555_5555, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_REMOVE, 32'haaaa_aaaa, 16'h0000, 1'b0,
          '{rsst_pkg::ST_DONE, 32'h0, 7'd0}},
        '{rsst_pkg::FUNC_SAMPLE, 32'h0000_0000, 16'h8000, 1'b1,
          '{rsst_pkg::ST_EMPTY, 32'h0, 7'd0}}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic rsp_word_t apply_request(input rsst_pkg::func_t f,
                                                input rsst_pkg::value_t v,
                                                input rsst_pkg::draw_t d);
        rsp_word_t r;
        int        slot;
        slot = -1;
        r.status  = rsst_pkg::ST_DONE;
        r.sampled = '0;
        for (int i = 0; i < live_cnt; i++)
        begin
            if (slot < 0 && set_mirror[i] == v)
                slot = i;
        end
        unique case (f)
            rsst_pkg::FUNC_INSERT:
            begin
                if (slot >= 0)
                    r.status = rsst_pkg::ST_MISS;
                else if (live_cnt >= rsst_pkg::CAPACITY)
                    r.status = rsst_pkg::ST_FULL;
                else
                begin
                    set_mirror[live_cnt] = v;
                    live_cnt++;
                end
            end
            rsst_pkg::FUNC_REMOVE:
            begin
                if (slot < 0)
                    r.status = rsst_pkg::ST_MISS;
                else
                begin
                    set_mirror[slot] = set_mirror[live_cnt - 1];
                    live_cnt--;
                end
            end
            rsst_pkg::FUNC_SAMPLE:
            begin
                if (live_cnt == 0)
                    r.status = rsst_pkg::ST_EMPTY;
                else
                    r.sampled = set_mirror[int'(d) % live_cnt];
            end
            default:
            begin
            end
        endcase
        r.count = rsst_pkg::count_t'(live_cnt);
        return r;
    endfunction

    function automatic rsst_pkg::value_t pick_value(input logic from_set);
        if (from_set && live_cnt > 0)
            return set_mirror[$urandom_range(0, live_cnt - 1)];
        if ($urandom_range(0, 2) == 0)
            return rsst_pkg::value_t'($signed($urandom_range(0, 15)) - 8);
        return rsst_pkg::value_t'($urandom);
    endfunction

    task automatic send_word(input rsst_pkg::func_t f, input rsst_pkg::value_t v,
                             input rsst_pkg::draw_t d, input logic literal,
                             input rsp_word_t literal_rsp);
        rsp_word_t predicted;
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.value       <= v;
        req_ch.random_draw <= d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(f, v, d);
        if (literal)
            predicted = literal_rsp;
        pending_rsp = {pending_rsp, predicted};
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        else
            burst_left--;
    endtask

    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 200);
            ready_mask = 16'($urandom);
        end
        else
            ready_left--;
        unique case (ready_mode)
            READY_ALWAYS: rsp_ch.ready <= 1'b1;
            READY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ch.ready <= ready_mask[ready_left % 16];
        endcase
    end

    always @(posedge clk)
    begin
        rsp_word_t exp_rsp;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp_ch.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.sampled_value !== exp_rsp.sampled)
                    begin
                        $error("sampled_value: expected %0d, actual %0d",
                               exp_rsp.sampled, rsp_ch.sampled_value);
                        mismatches++;
                    end
                    if (rsp_ch.element_count !== exp_rsp.count)
                    begin
                        $error("element_count: expected %0d, actual %0d",
                               exp_rsp.count, rsp_ch.element_count);
                        mismatches++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rsst_pkg::func_t  f;
        rsst_pkg::value_t v;
        rsst_pkg::draw_t  d;
        logic             grow;
        int               pick;
        int               ins_cut;
        int               rem_cut;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = rsst_pkg::FUNC_NOP;
        req_ch.value       = '0;
        req_ch.random_draw = '0;
        rsp_ch.ready       = 1'b0;
        live_cnt           = 0;
        mismatches         = 0;
        idle_cycles        = 0;
        burst_left         = 5;
        ready_mode         = READY_ALWAYS;
        ready_left         = 0;
        ready_mask         = '1;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            send_word(script[i].func, script[i].value, script[i].draw,
                      script[i].literal, script[i].rsp);

        // The set is driven from empty to full and back again, so that full inserts,
        // empty samples and hits at every position are reached many times.
        grow = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (live_cnt == rsst_pkg::CAPACITY && $urandom_range(0, 7) == 0)
                grow = 1'b0;
            else if (live_cnt == 0 && $urandom_range(0, 3) == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 299) == 0)
                grow = !grow;
            ins_cut = grow ? 65 : 10;
            rem_cut = grow ? 75 : 70;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                d = $urandom_range(0, 1) ? '1 : '0;
            else
                d = rsst_pkg::draw_t'($urandom_range(0, 65535));
            if (pick < ins_cut)
            begin
                f = rsst_pkg::FUNC_INSERT;
                v = pick_value($urandom_range(0, 9) < (grow ? 1 : 5));
            end
            else if (pick < rem_cut)
            begin
                f = rsst_pkg::FUNC_REMOVE;
                v = pick_value($urandom_range(0, 99) < (grow ? 50 : 85));
            end
            else if (pick < 95)
            begin
                f = rsst_pkg::FUNC_SAMPLE;
                v = rsst_pkg::value_t'($urandom);
            end
            else
            begin
                f = rsst_pkg::FUNC_NOP;
                v = rsst_pkg::value_t'($urandom);
            end
            send_word(f, v, d, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rsst_pkg.sv
rtl/rsst_if.sv
rtl/rsst_ram.sv
rtl/random_sampling_set_table_unit.sv
tb/tb_top.sv
